### rtl/core/uartrb_pkg.sv
// Shared types and constants for the UART receive/transmit ring buffer unit.
package uartrb_pkg;

  // Default ring depths (one slot always stays free)
  localparam int unsigned RX_DEPTH_DEF = 32;
  localparam int unsigned TX_DEPTH_DEF = 32;

  // Item operation codes
  localparam logic [1:0] OP_RX_BYTE  = 2'd0;
  localparam logic [1:0] OP_HOST_RD  = 2'd1;
  localparam logic [1:0] OP_HOST_WR  = 2'd2;
  localparam logic [1:0] OP_TX_READY = 2'd3;

  // Latched error bits: frame, overrun, ring overflow
  localparam int unsigned ERR_FRAME_BIT   = 0;
  localparam int unsigned ERR_OVERRUN_BIT = 1;
  localparam int unsigned ERR_OVERFLOW_BIT = 2;
  localparam logic [2:0]  ERR_NONE        = 3'b000;
  localparam logic [2:0]  ERR_OVERFLOW    = 3'b100;

  // Decoded operation class, one-hot
  typedef struct packed {
    logic rx_byte;
    logic host_rd;
    logic host_wr;
    logic tx_ready;
  } cls_t;

  // Classified item as held in the queue
  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
    logic       frame_err;
    logic       overrun_err;
  } item_t;

endpackage

### rtl/core/uartrb_front.sv
// Front end: accepts items, decodes the operation and queues them for the back end.
module uartrb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_data_in,
  input  logic                in_frame_error,
  input  logic                in_overrun_error,
  output logic                q_valid,
  output uartrb_pkg::item_t   q_head
);

  uartrb_pkg::item_t q_mem_r [2];
  logic       q_wptr_r, q_wptr_nxt;
  logic       q_rptr_r, q_rptr_nxt;
  logic [1:0] q_cnt_r,  q_cnt_nxt;
  logic       push, pop;
  uartrb_pkg::cls_t  cls;
  uartrb_pkg::item_t item;

  // Operation decode
  always_comb begin
    cls = '0;
    unique case (in_op)
      uartrb_pkg::OP_RX_BYTE:  cls.rx_byte  = 1'b1;
      uartrb_pkg::OP_HOST_RD:  cls.host_rd  = 1'b1;
      uartrb_pkg::OP_HOST_WR:  cls.host_wr  = 1'b1;
      uartrb_pkg::OP_TX_READY: cls.tx_ready = 1'b1;
      default:                 cls = '0;
    endcase
  end

  assign item = '{cls: cls, data: in_data_in, frame_err: in_frame_error,
                  overrun_err: in_overrun_error};

  // Two-entry queue; the back end drains one item every cycle
  assign busy    = (q_cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (q_cnt_r != 2'd0);
  assign pop     = q_valid;
  assign q_head  = q_mem_r[q_rptr_r];

  always_comb begin
    q_wptr_nxt = push ? ~q_wptr_r : q_wptr_r;
    q_rptr_nxt = pop  ? ~q_rptr_r : q_rptr_r;
    q_cnt_nxt  = q_cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wptr_r <= 1'b0;
      q_rptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      q_wptr_r <= q_wptr_nxt;
      q_rptr_r <= q_rptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wptr_r] <= item;
    end
  end

endmodule

### rtl/core/uartrb_back.sv
// Back end: ring pointers, byte stores, error latch and result registers.
module uartrb_back #(
  parameter int unsigned RX_DEPTH = uartrb_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  uartrb_pkg::item_t q_head,
  output logic              out_valid,
  output logic [7:0]        out_read_data,
  output logic              out_no_data,
  output logic              out_err_frame,
  output logic              out_err_overrun,
  output logic              out_err_overflow,
  output logic [7:0]        out_tx_byte,
  output logic              out_tx_valid,
  output logic              out_tx_rejected,
  output logic              out_tx_irq_on
);

  localparam int unsigned RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  // Byte stores
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RX_AW-1:0] rx_wptr_r, rx_wptr_nxt, rx_rptr_r, rx_rptr_nxt;
  logic [TX_AW-1:0] tx_wptr_r, tx_wptr_nxt, tx_rptr_r, tx_rptr_nxt;
  logic [RX_AW-1:0] rx_wnext, rx_rnext;
  logic [TX_AW-1:0] tx_wnext, tx_rnext;
  logic [2:0] last_err_r, last_err_nxt;
  logic       irq_r, irq_nxt;

  logic       out_valid_r, rd_hit_r, rd_hit_nxt, no_data_r, no_data_nxt;
  logic [2:0] err_out_r, err_out_nxt;
  logic       tx_v_r, tx_v_nxt, tx_rej_r, tx_rej_nxt;
  logic [7:0] rx_q_r, tx_q_r;

  logic rx_full, rx_empty, tx_full, tx_empty;
  logic rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
  uartrb_pkg::cls_t cls;

  assign cls = q_head.cls;

  // Ring status and wrapped next pointers
  assign rx_wnext = (rx_wptr_r == RX_LAST) ? '0 : rx_wptr_r + 1'b1;
  assign rx_rnext = (rx_rptr_r == RX_LAST) ? '0 : rx_rptr_r + 1'b1;
  assign tx_wnext = (tx_wptr_r == TX_LAST) ? '0 : tx_wptr_r + 1'b1;
  assign tx_rnext = (tx_rptr_r == TX_LAST) ? '0 : tx_rptr_r + 1'b1;
  assign rx_full  = (rx_wnext == rx_rptr_r);
  assign rx_empty = (rx_wptr_r == rx_rptr_r);
  assign tx_full  = (tx_wnext == tx_rptr_r);
  assign tx_empty = (tx_wptr_r == tx_rptr_r);

  assign rx_wr_en = q_valid && cls.rx_byte  && !rx_full;
  assign rx_rd_en = q_valid && cls.host_rd  && !rx_empty;
  assign tx_wr_en = q_valid && cls.host_wr  && !tx_full;
  assign tx_rd_en = q_valid && cls.tx_ready && !tx_empty;

  // Next state for pointers, error latch, interrupt enable and result flags
  always_comb begin
    rx_wptr_nxt  = rx_wr_en ? rx_wnext : rx_wptr_r;
    rx_rptr_nxt  = rx_rd_en ? rx_rnext : rx_rptr_r;
    tx_wptr_nxt  = tx_wr_en ? tx_wnext : tx_wptr_r;
    tx_rptr_nxt  = tx_rd_en ? tx_rnext : tx_rptr_r;
    last_err_nxt = last_err_r;
    irq_nxt      = irq_r;
    if (q_valid && cls.rx_byte) begin
      last_err_nxt = rx_full ? uartrb_pkg::ERR_OVERFLOW
                             : {1'b0, q_head.overrun_err, q_head.frame_err};
    end
    if (tx_wr_en) begin
      irq_nxt = 1'b1;
    end
    if (q_valid && cls.tx_ready && tx_empty) begin
      irq_nxt = 1'b0;
    end
    rd_hit_nxt  = rx_rd_en;
    no_data_nxt = cls.host_rd && rx_empty;
    err_out_nxt = cls.host_rd ? last_err_r : uartrb_pkg::ERR_NONE;
    tx_v_nxt    = tx_rd_en;
    tx_rej_nxt  = cls.host_wr && tx_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wptr_r   <= '0;
      rx_rptr_r   <= '0;
      tx_wptr_r   <= '0;
      tx_rptr_r   <= '0;
      last_err_r  <= uartrb_pkg::ERR_NONE;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_wptr_r   <= rx_wptr_nxt;
      rx_rptr_r   <= rx_rptr_nxt;
      tx_wptr_r   <= tx_wptr_nxt;
      tx_rptr_r   <= tx_rptr_nxt;
      last_err_r  <= last_err_nxt;
      irq_r       <= irq_nxt;
      out_valid_r <= q_valid;
    end
  end

  // Result flags, loaded with each executed item
  always_ff @(posedge clk) begin
    if (q_valid) begin
      rd_hit_r  <= rd_hit_nxt;
      no_data_r <= no_data_nxt;
      err_out_r <= err_out_nxt;
      tx_v_r    <= tx_v_nxt;
      tx_rej_r  <= tx_rej_nxt;
    end
  end

  // Receive store: write at next write slot, registered read at next read slot
  always_ff @(posedge clk) begin
    if (rx_wr_en) begin
      rx_mem[rx_wnext] <= q_head.data;
    end
    if (rx_rd_en) begin
      rx_q_r <= rx_mem[rx_rnext];
    end
  end

  // Transmit store
  always_ff @(posedge clk) begin
    if (tx_wr_en) begin
      tx_mem[tx_wnext] <= q_head.data;
    end
    if (tx_rd_en) begin
      tx_q_r <= tx_mem[tx_rnext];
    end
  end

  // Result ports; fields that do not apply read as zero
  assign out_valid        = out_valid_r;
  assign out_read_data    = rd_hit_r ? rx_q_r : 8'h00;
  assign out_no_data      = no_data_r;
  assign out_err_frame    = err_out_r[uartrb_pkg::ERR_FRAME_BIT];
  assign out_err_overrun  = err_out_r[uartrb_pkg::ERR_OVERRUN_BIT];
  assign out_err_overflow = err_out_r[uartrb_pkg::ERR_OVERFLOW_BIT];
  assign out_tx_byte      = tx_v_r ? tx_q_r : 8'h00;
  assign out_tx_valid     = tx_v_r;
  assign out_tx_rejected  = tx_rej_r;
  assign out_tx_irq_on    = irq_r;

`ifndef SYNTHESIS
  // Every executed item yields a result strobe in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |=> out_valid_r)
    else $error("executed item produced no result");

  // A stored received byte leaves the receive ring non-empty
  a_rx_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rx_wr_en |=> (rx_wptr_r != rx_rptr_r))
    else $error("receive ring empty after store");

  // A read either returns data or reports empty, never both
  a_rd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(rd_hit_r && no_data_r))
    else $error("read returned data and no_data together");

  // An accepted host write always leaves the interrupt enabled
  a_irq_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    tx_wr_en |=> irq_r)
    else $error("interrupt not enabled after host write");
`endif

endmodule

### rtl/core/uart_rx_tx_ring_buffers_unit.sv
// Top level of the UART receive/transmit ring buffer unit.
// Each item (start high while busy is low) is decoded and queued by the front
// end, then executed by the back end, which takes one queued item per clock.
// Its result appears on the out_ ports with out_valid high for exactly one
// cycle, after the item has passed the front-end queue and the back end's
// result registers; the receiver cannot hold results off, so out_valid must
// be sampled every cycle. Items may be issued on every clock: the back end
// drains the two-entry queue at one item per cycle, so busy does not rise in
// practice. The receive and transmit rings each keep one slot free and hold at
// most depth minus one bytes. No clearing pass is needed after reset.
module uart_rx_tx_ring_buffers_unit #(
  parameter int unsigned RX_DEPTH = uartrb_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_in,
  input  logic       in_frame_error,
  input  logic       in_overrun_error,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic       out_no_data,
  output logic       out_err_frame,
  output logic       out_err_overrun,
  output logic       out_err_overflow,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_valid,
  output logic       out_tx_rejected,
  output logic       out_tx_irq_on
);

  logic              q_valid;
  uartrb_pkg::item_t q_head;

  uartrb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_data_in       (in_data_in),
    .in_frame_error   (in_frame_error),
    .in_overrun_error (in_overrun_error),
    .q_valid          (q_valid),
    .q_head           (q_head)
  );

  uartrb_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .out_valid        (out_valid),
    .out_read_data    (out_read_data),
    .out_no_data      (out_no_data),
    .out_err_frame    (out_err_frame),
    .out_err_overrun  (out_err_overrun),
    .out_err_overflow (out_err_overflow),
    .out_tx_byte      (out_tx_byte),
    .out_tx_valid     (out_tx_valid),
    .out_tx_rejected  (out_tx_rejected),
    .out_tx_irq_on    (out_tx_irq_on)
  );

endmodule
